/* hdl/tsp_pkg.sv */
package tsp_pkg;

  localparam int unsigned ENTRY_W = 20;
  localparam int unsigned CFG_W   = 20;

  localparam logic [3:0] PH_VERSION   = 4'd0;
  localparam logic [3:0] PH_IN_COUNT  = 4'd1;
  localparam logic [3:0] PH_HASH      = 4'd2;
  localparam logic [3:0] PH_INDEX     = 4'd3;
  localparam logic [3:0] PH_SIG_LEN   = 4'd4;
  localparam logic [3:0] PH_SIG_BYTE  = 4'd5;
  localparam logic [3:0] PH_SEQUENCE  = 4'd6;
  localparam logic [3:0] PH_OUT_COUNT = 4'd7;
  localparam logic [3:0] PH_AMOUNT    = 4'd8;
  localparam logic [3:0] PH_PK_LEN    = 4'd9;
  localparam logic [3:0] PH_PK_BYTE   = 4'd10;
  localparam logic [3:0] PH_LOCKTIME  = 4'd11;
  localparam logic [3:0] PH_SKIP      = 4'd12;
  localparam logic [3:0] PH_TRAIL     = 4'd13;

  localparam logic [3:0] KIND_IGNORED = 4'd12;

  localparam logic [2:0] ST_PARSING   = 3'd0;
  localparam logic [2:0] ST_OK        = 3'd1;
  localparam logic [2:0] ST_TRUNCATED = 3'd2;
  localparam logic [2:0] ST_MANY_IN   = 3'd3;
  localparam logic [2:0] ST_MANY_OUT  = 3'd4;
  localparam logic [2:0] ST_SCRIPT    = 3'd5;
  localparam logic [2:0] ST_EXTRA     = 3'd6;

  localparam logic [1:0] CFG_MAX_IN     = 2'd0;
  localparam logic [1:0] CFG_MAX_OUT    = 2'd1;
  localparam logic [1:0] CFG_MAX_SCRIPT = 2'd2;

  localparam logic [19:0] RST_MAX_IN     = 20'd100000;
  localparam logic [19:0] RST_MAX_OUT    = 20'd100000;
  localparam logic [15:0] RST_MAX_SCRIPT = 16'd10000;

  localparam logic [7:0] COMPACT_P16 = 8'd253;
  localparam logic [7:0] COMPACT_P32 = 8'd254;

  localparam logic [5:0] HASH_BYTES = 6'd32;

  localparam logic [3:0] LEN_NONE    = 4'd0;
  localparam logic [3:0] LEN_COMPACT = 4'd1;
  localparam logic [3:0] LEN_WORD    = 4'd4;
  localparam logic [3:0] LEN_AMOUNT  = 4'd8;
  localparam logic [3:0] LEN_EXT16   = 4'd3;
  localparam logic [3:0] LEN_EXT32   = 4'd5;
  localparam logic [3:0] LEN_EXT64   = 4'd9;

  typedef struct packed {
    logic [19:0] max_in;
    logic [19:0] max_out;
    logic [15:0] max_script;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [3:0]         kind;
    logic [7:0]         echo;
    logic               vvalid;
    logic [63:0]        value;
    logic [ENTRY_W-1:0] entry;
    logic [2:0]         status;
    logic               done;
  } result_t;

endpackage

/* hdl/tsp_cfg.sv */
module tsp_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      we_i,
  input  logic [1:0]                idx_i,
  input  logic [tsp_pkg::CFG_W-1:0] wdata_i,
  output tsp_pkg::cfg_t             cfg_o
);

  tsp_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (idx_i)
        tsp_pkg::CFG_MAX_IN:     cfg_d.max_in     = wdata_i;
        tsp_pkg::CFG_MAX_OUT:    cfg_d.max_out    = wdata_i;
        tsp_pkg::CFG_MAX_SCRIPT: cfg_d.max_script = wdata_i[15:0];
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_in     <= tsp_pkg::RST_MAX_IN;
      cfg_q.max_out    <= tsp_pkg::RST_MAX_OUT;
      cfg_q.max_script <= tsp_pkg::RST_MAX_SCRIPT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/tsp_in_stage.sv */
module tsp_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  tsp_pkg::item_t item_i,
  input  logic           adv_i,
  output logic           valid_o,
  output tsp_pkg::item_t item_o
);

  logic           vld_q, vld_d;
  tsp_pkg::item_t item_q;

  assign ready_o = !vld_q || adv_i;

  always_comb begin
    vld_d = vld_q;
    if (valid_i && ready_o) begin
      vld_d = 1'b1;
    end else if (adv_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = vld_q;
  assign item_o  = item_q;

endmodule

/* hdl/tsp_core.sv */
module tsp_core #(
  parameter int unsigned COUNT_WIDTH      = 20,
  parameter int unsigned SCRIPT_LEN_WIDTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  tsp_pkg::item_t   item_i,
  input  tsp_pkg::cfg_t    cfg_i,
  output tsp_pkg::result_t res_o
);

  localparam logic [63:0] CntMask = (64'd1 << COUNT_WIDTH) - 64'd1;
  localparam logic [63:0] LenMask = (64'd1 << SCRIPT_LEN_WIDTH) - 64'd1;

  logic [3:0]                  phase_q, phase_d;
  logic [5:0]                  fcnt_q, fcnt_d;
  logic [3:0]                  flen_q, flen_d;
  logic [63:0]                 acc_q, acc_d;
  logic [COUNT_WIDTH-1:0]      erem_q, erem_d;
  logic [COUNT_WIDTH-1:0]      cent_q, cent_d;
  logic [SCRIPT_LEN_WIDTH-1:0] srem_q, srem_d;
  logic [2:0]                  err_q, err_d;

  logic [7:0]  b;
  logic        is_compact, first_compact, num_done, tx_ok, start;
  logic [5:0]  fcnt_inc, pos;
  logic [63:0] acc_new, num_val, cap_in, cap_out, cap_script;
  logic [3:0]  nphase, nlen;
  logic [2:0]  status;

  assign b        = item_i.data;
  assign fcnt_inc = fcnt_q + 6'd1;

  assign cap_in     = (64'(cfg_i.max_in) < CntMask) ? 64'(cfg_i.max_in) : CntMask;
  assign cap_out    = (64'(cfg_i.max_out) < CntMask) ? 64'(cfg_i.max_out) : CntMask;
  assign cap_script = (64'(cfg_i.max_script) < LenMask) ? 64'(cfg_i.max_script) : LenMask;

  assign is_compact = (phase_q == tsp_pkg::PH_IN_COUNT) || (phase_q == tsp_pkg::PH_SIG_LEN) ||
                      (phase_q == tsp_pkg::PH_OUT_COUNT) || (phase_q == tsp_pkg::PH_PK_LEN);
  assign first_compact = is_compact && (fcnt_q == 6'd0);
  assign pos     = is_compact ? fcnt_q - 6'd1 : fcnt_q;
  assign acc_new = acc_q | ({56'd0, b} << {pos[2:0], 3'b000});
  assign num_val = first_compact ? {56'd0, b} : acc_new;

  always_comb begin
    phase_d  = phase_q;
    fcnt_d   = fcnt_q;
    flen_d   = flen_q;
    acc_d    = acc_q;
    erem_d   = erem_q;
    cent_d   = cent_q;
    srem_d   = srem_q;
    err_d    = err_q;
    num_done = 1'b0;
    tx_ok    = 1'b0;
    start    = 1'b0;
    nphase   = phase_q;
    nlen     = flen_q;

    res_o.kind   = (phase_q < tsp_pkg::PH_SKIP) ? phase_q : tsp_pkg::KIND_IGNORED;
    res_o.echo   = b;
    res_o.vvalid = 1'b0;
    res_o.value  = '0;
    res_o.entry  = '0;
    res_o.done   = item_i.last;
    if ((phase_q >= tsp_pkg::PH_HASH && phase_q <= tsp_pkg::PH_SEQUENCE) ||
        (phase_q >= tsp_pkg::PH_AMOUNT && phase_q <= tsp_pkg::PH_PK_BYTE)) begin
      res_o.entry = tsp_pkg::ENTRY_W'(cent_q);
    end

    unique case (phase_q)
      tsp_pkg::PH_HASH: begin
        fcnt_d = fcnt_inc;
        if (fcnt_inc >= tsp_pkg::HASH_BYTES) begin
          start = 1'b1; nphase = tsp_pkg::PH_INDEX; nlen = tsp_pkg::LEN_WORD;
        end
      end
      tsp_pkg::PH_SIG_BYTE: begin
        srem_d = srem_q - SCRIPT_LEN_WIDTH'(1);
        if (srem_q == SCRIPT_LEN_WIDTH'(1)) begin
          start = 1'b1; nphase = tsp_pkg::PH_SEQUENCE; nlen = tsp_pkg::LEN_WORD;
        end
      end
      tsp_pkg::PH_PK_BYTE: begin
        srem_d = srem_q - SCRIPT_LEN_WIDTH'(1);
        if (srem_q == SCRIPT_LEN_WIDTH'(1)) begin
          erem_d = erem_q - COUNT_WIDTH'(1);
          start  = 1'b1;
          if (erem_q == COUNT_WIDTH'(1)) begin
            cent_d = '0; nphase = tsp_pkg::PH_LOCKTIME; nlen = tsp_pkg::LEN_WORD;
          end else begin
            cent_d = cent_q + COUNT_WIDTH'(1);
            nphase = tsp_pkg::PH_AMOUNT; nlen = tsp_pkg::LEN_AMOUNT;
          end
        end
      end
      tsp_pkg::PH_SKIP: begin
      end
      tsp_pkg::PH_TRAIL: begin
        err_d   = tsp_pkg::ST_EXTRA;
        phase_d = tsp_pkg::PH_SKIP;
      end
      default: begin
        if (first_compact) begin
          fcnt_d = 6'd1;
          if (b < tsp_pkg::COMPACT_P16) begin
            acc_d    = {56'd0, b};
            num_done = 1'b1;
          end else begin
            acc_d  = '0;
            flen_d = (b == tsp_pkg::COMPACT_P16) ? tsp_pkg::LEN_EXT16 :
                     (b == tsp_pkg::COMPACT_P32) ? tsp_pkg::LEN_EXT32 : tsp_pkg::LEN_EXT64;
          end
        end else begin
          acc_d    = acc_new;
          fcnt_d   = fcnt_inc;
          num_done = fcnt_inc >= {2'b00, flen_q};
        end

        if (num_done) begin
          res_o.vvalid = 1'b1;
          res_o.value  = num_val;
          unique case (phase_q)
            tsp_pkg::PH_VERSION: begin
              start = 1'b1; nphase = tsp_pkg::PH_IN_COUNT; nlen = tsp_pkg::LEN_COMPACT;
            end
            tsp_pkg::PH_IN_COUNT: begin
              if (num_val > cap_in) begin
                err_d = tsp_pkg::ST_MANY_IN;
              end else begin
                erem_d = num_val[COUNT_WIDTH-1:0];
                cent_d = '0;
                start  = 1'b1;
                if (num_val == 64'd0) begin
                  nphase = tsp_pkg::PH_OUT_COUNT; nlen = tsp_pkg::LEN_COMPACT;
                end else begin
                  nphase = tsp_pkg::PH_HASH; nlen = tsp_pkg::LEN_NONE;
                end
              end
            end
            tsp_pkg::PH_INDEX: begin
              start = 1'b1; nphase = tsp_pkg::PH_SIG_LEN; nlen = tsp_pkg::LEN_COMPACT;
            end
            tsp_pkg::PH_SIG_LEN: begin
              if (num_val > cap_script) begin
                err_d = tsp_pkg::ST_SCRIPT;
              end else begin
                srem_d = num_val[SCRIPT_LEN_WIDTH-1:0];
                start  = 1'b1;
                if (num_val == 64'd0) begin
                  nphase = tsp_pkg::PH_SEQUENCE; nlen = tsp_pkg::LEN_WORD;
                end else begin
                  nphase = tsp_pkg::PH_SIG_BYTE; nlen = tsp_pkg::LEN_NONE;
                end
              end
            end
            tsp_pkg::PH_SEQUENCE: begin
              erem_d = erem_q - COUNT_WIDTH'(1);
              start  = 1'b1;
              if (erem_q == COUNT_WIDTH'(1)) begin
                cent_d = '0; nphase = tsp_pkg::PH_OUT_COUNT; nlen = tsp_pkg::LEN_COMPACT;
              end else begin
                cent_d = cent_q + COUNT_WIDTH'(1);
                nphase = tsp_pkg::PH_HASH; nlen = tsp_pkg::LEN_NONE;
              end
            end
            tsp_pkg::PH_OUT_COUNT: begin
              if (num_val > cap_out) begin
                err_d = tsp_pkg::ST_MANY_OUT;
              end else begin
                erem_d = num_val[COUNT_WIDTH-1:0];
                cent_d = '0;
                start  = 1'b1;
                if (num_val == 64'd0) begin
                  nphase = tsp_pkg::PH_LOCKTIME; nlen = tsp_pkg::LEN_WORD;
                end else begin
                  nphase = tsp_pkg::PH_AMOUNT; nlen = tsp_pkg::LEN_AMOUNT;
                end
              end
            end
            tsp_pkg::PH_AMOUNT: begin
              start = 1'b1; nphase = tsp_pkg::PH_PK_LEN; nlen = tsp_pkg::LEN_COMPACT;
            end
            tsp_pkg::PH_PK_LEN: begin
              if (num_val > cap_script) begin
                err_d = tsp_pkg::ST_SCRIPT;
              end else begin
                srem_d = num_val[SCRIPT_LEN_WIDTH-1:0];
                start  = 1'b1;
                if (num_val != 64'd0) begin
                  nphase = tsp_pkg::PH_PK_BYTE; nlen = tsp_pkg::LEN_NONE;
                end else if (erem_q == COUNT_WIDTH'(1)) begin
                  erem_d = erem_q - COUNT_WIDTH'(1);
                  cent_d = '0; nphase = tsp_pkg::PH_LOCKTIME; nlen = tsp_pkg::LEN_WORD;
                end else begin
                  erem_d = erem_q - COUNT_WIDTH'(1);
                  cent_d = cent_q + COUNT_WIDTH'(1);
                  nphase = tsp_pkg::PH_AMOUNT; nlen = tsp_pkg::LEN_AMOUNT;
                end
              end
            end
            default: begin
              tx_ok = 1'b1;
              start = 1'b1; nphase = tsp_pkg::PH_TRAIL; nlen = tsp_pkg::LEN_NONE;
            end
          endcase
        end
      end
    endcase

    if (start) begin
      phase_d = nphase;
      fcnt_d  = '0;
      flen_d  = nlen;
      acc_d   = '0;
    end

    status = err_d;
    if (item_i.last) begin
      if (err_d == tsp_pkg::ST_PARSING) begin
        status = tx_ok ? tsp_pkg::ST_OK : tsp_pkg::ST_TRUNCATED;
      end
      phase_d = tsp_pkg::PH_VERSION;
      fcnt_d  = '0;
      flen_d  = tsp_pkg::LEN_WORD;
      acc_d   = '0;
      erem_d  = '0;
      cent_d  = '0;
      srem_d  = '0;
      err_d   = tsp_pkg::ST_PARSING;
    end else if (err_d != tsp_pkg::ST_PARSING) begin
      phase_d = tsp_pkg::PH_SKIP;
    end
    res_o.status = status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tsp_pkg::PH_VERSION;
      fcnt_q  <= '0;
      flen_q  <= tsp_pkg::LEN_WORD;
      acc_q   <= '0;
      erem_q  <= '0;
      cent_q  <= '0;
      srem_q  <= '0;
      err_q   <= tsp_pkg::ST_PARSING;
    end else if (fire_i) begin
      phase_q <= phase_d;
      fcnt_q  <= fcnt_d;
      flen_q  <= flen_d;
      acc_q   <= acc_d;
      erem_q  <= erem_d;
      cent_q  <= cent_d;
      srem_q  <= srem_d;
      err_q   <= err_d;
    end
  end

endmodule

/* hdl/tsp_out_stage.sv */
module tsp_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  tsp_pkg::result_t res_i,
  input  logic             ready_i,
  output logic             adv_o,
  output logic             valid_o,
  output tsp_pkg::result_t res_o
);

  logic             vld_q;
  tsp_pkg::result_t res_q;

  assign adv_o = !vld_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_o) begin
      vld_q <= fire_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = vld_q;
  assign res_o   = res_q;

endmodule

/* hdl/transaction_stream_parser.sv */
// Byte-serial parser for one serialized legacy transaction.
// Slave channel: one transaction byte per word in tdata, tlast on the final
// byte of the buffer. Master channel: one result word per input byte, with
// field kind and value-valid flag in tuser, echo, value, entry index and
// status in tdata, and tlast copying the input's last flag.
// Configuration: write the input, output and script limits through
// cfg_we_i/cfg_idx_i/cfg_wdata_i while no byte is in flight.
// Path: each byte is held in the input register, and its result in the result register.
// Throughput: one byte per cycle unless the master side stalls; each byte is
// one pass through the field tracker from input register to result register.
// Reset: clears the parse state to the version field and loads the default
// limits; no clearing sweep is needed.
// Stall: while tready on the master side is low the result word holds, the
// input register takes a byte only if it is empty, then s_axis_tready_o drops
// until the result is taken.
module transaction_stream_parser #(
  parameter int unsigned COUNT_WIDTH      = 20,
  parameter int unsigned SCRIPT_LEN_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] data_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] byte_echo, [71:8] field_value, [91:72] entry_index, [94:92] status, [95] zero
  output logic [95:0] m_axis_tdata_o,
  // [3:0] field_kind, [4] value_valid, [7:5] zero
  output logic [7:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [19:0] cfg_wdata_i
);

  tsp_pkg::cfg_t    cfg;
  tsp_pkg::item_t   in_item, item;
  tsp_pkg::result_t res, res_out;
  logic             item_vld, adv, fire;

  assign in_item.data = s_axis_tdata_i;
  assign in_item.last = s_axis_tlast_i;
  assign fire         = item_vld && adv;

  tsp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  tsp_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .item_i  (in_item),
    .adv_i   (adv),
    .valid_o (item_vld),
    .item_o  (item)
  );

  tsp_core #(
    .COUNT_WIDTH      (COUNT_WIDTH),
    .SCRIPT_LEN_WIDTH (SCRIPT_LEN_WIDTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  tsp_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .res_i   (res),
    .ready_i (m_axis_tready_i),
    .adv_o   (adv),
    .valid_o (m_axis_tvalid_o),
    .res_o   (res_out)
  );

  assign m_axis_tdata_o = {1'b0, res_out.status, res_out.entry, res_out.value, res_out.echo};
  assign m_axis_tuser_o = {3'b000, res_out.vvalid, res_out.kind};
  assign m_axis_tlast_o = res_out.done;

endmodule

/* hdl/tsp_checker.sv */
module tsp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [95:0] m_axis_tdata_o,
  input logic [7:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) &&
    $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o))
    else $error("result word changed while stalled");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without a stalled result");

  a_value_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[4] |-> m_axis_tdata_o[71:8] == 64'd0)
    else $error("field value set without value valid");

  a_last_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tdata_o[94:92] != tsp_pkg::ST_PARSING)
    else $error("last word reports parsing status");

  a_ok_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[94:92] == tsp_pkg::ST_OK |-> m_axis_tlast_o &&
    m_axis_tuser_o[3:0] == tsp_pkg::PH_LOCKTIME)
    else $error("done status off the final locktime byte");

endmodule

bind transaction_stream_parser tsp_checker u_checker (.*);
